@@ design/eks_pkg.sv @@
// Shared types, codes and defaults for the expiring key set.
package eks_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int DEF_KEY_BITS = 32;

  localparam int KEY_W  = 32;
  localparam int TIME_W = 48;
  localparam int RET_W  = 32;
  localparam int OCC_W  = 5;

  localparam logic [RET_W-1:0] RET_RESET = 32'd1000;

  localparam logic FUNC_ADD    = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  typedef struct packed {
    logic              func;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] now_time;
  } eks_req_t;

  typedef struct packed {
    logic             hit;
    logic [OCC_W-1:0] occupancy;
  } eks_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } eks_state_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic update;
  } eks_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } eks_sts_t;

endpackage

@@ design/eks_ctrl.sv @@
// Controller state machine: accept, scan and compact, then update and report.
module eks_ctrl
  import eks_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  eks_sts_t sts,
  output eks_cmd_t cmd
);

  eks_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_done) state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // No request beat is taken while reset is held.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready  = !rst;
        cmd.start = in_valid && !rst;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      ST_UPDATE: begin
        cmd.update = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ design/eks_dp.sv @@
// Datapath: entry memories, scan and compaction counters, update and output register.
module eks_dp
  import eks_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY,
  parameter int KEY_BITS = DEF_KEY_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  eks_req_t         in_data,
  input  logic             cfg_valid,
  input  logic [RET_W-1:0] cfg_data,
  input  eks_cmd_t         cmd,
  output eks_sts_t         sts,
  output logic             out_valid,
  input  logic             out_ready,
  output eks_rsp_t         out_data
);

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int SUM_W  = CNT_W + 1;

  // Entries live in a ring: logical entry i sits at slot head + i, wrapped.
  logic [KEY_BITS-1:0] key_mem  [CAPACITY];
  logic [TIME_W-1:0]   mark_mem [CAPACITY];

  logic [RET_W-1:0]    retention;
  logic                req_func;
  logic [KEY_BITS-1:0] req_key;
  logic [TIME_W-1:0]   req_now;
  logic [KEY_BITS-1:0] in_key;

  logic [ADDR_W-1:0]   head, head_next;
  logic [CNT_W-1:0]    count, count_next;
  logic [CNT_W-1:0]    rd_idx;
  logic [CNT_W-1:0]    wr_idx;
  logic                rd_pend;
  logic                found;
  logic [ADDR_W-1:0]   pos;

  logic [KEY_BITS-1:0] rd_key;
  logic [TIME_W-1:0]   rd_mark;

  logic                scan_issue;
  logic [TIME_W-1:0]   age;
  logic                gone;
  logic                keep;
  logic                is_match;
  logic                do_refresh;
  logic                do_append;
  logic                full_append;

  logic [CNT_W-1:0]    wr_lidx;
  logic [ADDR_W-1:0]   rd_addr;
  logic [ADDR_W-1:0]   wr_addr;
  logic                key_we;
  logic                mark_we;
  logic [KEY_BITS-1:0] wr_key;
  logic [TIME_W-1:0]   wr_mark;

  function automatic logic [ADDR_W-1:0] ring_slot(input logic [ADDR_W-1:0] base,
                                                   input logic [CNT_W-1:0]  idx);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(idx);
    if (sum >= SUM_W'(CAPACITY)) begin
      sum = sum - SUM_W'(CAPACITY);
    end
    return sum[ADDR_W-1:0];
  endfunction

  generate
    if (KEY_BITS <= KEY_W) begin : g_key_narrow
      assign in_key = in_data.key[KEY_BITS-1:0];
    end else begin : g_key_wide
      assign in_key = {{(KEY_BITS - KEY_W){1'b0}}, in_data.key};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      retention <= RET_RESET;
    end else if (cfg_valid) begin
      retention <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_func <= in_data.func;
      req_key  <= in_key;
      req_now  <= in_data.now_time;
    end
  end

  // Scan: one read a cycle; the read data is registered, and survivors
  // are written back at the compaction pointer.
  assign scan_issue = cmd.scan && (rd_idx != count);
  assign age        = req_now - rd_mark;
  assign gone       = (req_now >= rd_mark) && (age >= TIME_W'(retention));
  assign keep       = rd_pend && !gone;
  assign is_match   = keep && (rd_key == req_key);

  assign do_refresh  = cmd.update && (req_func == FUNC_ADD) && found;
  assign do_append   = cmd.update && (req_func == FUNC_ADD) && !found;
  assign full_append = do_append && (wr_idx == CNT_W'(CAPACITY));

  always_comb begin
    count_next = count;
    head_next  = head;
    if (cmd.update) begin
      count_next = wr_idx;
      if (do_append && !full_append) begin
        count_next = wr_idx + CNT_W'(1);
      end
      if (full_append) begin
        // The oldest entry's slot takes the new key and the ring moves on.
        head_next = (head == ADDR_W'(CAPACITY - 1)) ? '0 : head + ADDR_W'(1);
      end
    end
  end

  assign wr_lidx = do_refresh ? CNT_W'(pos) : wr_idx;
  assign rd_addr = ring_slot(head, rd_idx);
  assign wr_addr = ring_slot(head, wr_lidx);
  assign key_we  = keep || do_append;
  assign mark_we = keep || do_append || do_refresh;
  assign wr_key  = keep ? rd_key : req_key;
  assign wr_mark = keep ? rd_mark : req_now;

  always_ff @(posedge clk) begin
    if (scan_issue) begin
      rd_key  <= key_mem[rd_addr];
      rd_mark <= mark_mem[rd_addr];
    end
    if (key_we) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (mark_we) begin
      mark_mem[wr_addr] <= wr_mark;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      count   <= '0;
      rd_idx  <= '0;
      wr_idx  <= '0;
      rd_pend <= 1'b0;
      found   <= 1'b0;
    end else begin
      head    <= head_next;
      count   <= count_next;
      rd_pend <= scan_issue;
      if (cmd.start) begin
        rd_idx <= '0;
        wr_idx <= '0;
        found  <= 1'b0;
      end else begin
        if (scan_issue) begin
          rd_idx <= rd_idx + CNT_W'(1);
        end
        if (keep) begin
          wr_idx <= wr_idx + CNT_W'(1);
        end
        if (is_match && !found) begin
          found <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_match && !found) begin
      pos <= wr_idx[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.update) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_data.hit       <= found;
      out_data.occupancy <= OCC_W'(count_next);
    end
  end

  // The scan is over once every live entry has been read; the last read's
  // data is still handled in this cycle.
  assign sts.scan_done = (rd_idx == count);
  assign sts.out_free  = !out_valid || out_ready;

endmodule

@@ design/expiring_key_set_core.sv @@
// Top level of the expiring key set: controller and datapath.
// A set of up to CAPACITY keys with mark times, kept oldest first in a ring held in
// single-port-read memories. Each request beat first sweeps the live entries one per
// cycle, dropping those whose age has reached the retention time and compacting the
// rest, while looking for the key; an add then refreshes the mark time in place or
// appends the key, evicting the oldest entry when the set is full. One request is
// handled at a time. The result sits in an output register, so a waiting result does
// not hold up the next request until that request reaches its update. The retention
// time is written on the configuration channel, which is ready whenever reset is low;
// the user must write it only while no request is in flight, as the block itself does
// not enforce this.
module expiring_key_set_core
  import eks_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY,
  parameter int KEY_BITS = DEF_KEY_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  eks_req_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output eks_rsp_t         out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [RET_W-1:0] cfg_data
);

  eks_cmd_t cmd;
  eks_sts_t sts;

  assign cfg_ready = !rst;

  eks_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  eks_dp #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
